// ----- rtl/iale_pkg.sv -----
`default_nettype none

package iale_pkg;

  // Fixed field widths of the request, result and configuration ports
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SELECT  = 3'd0,
    OP_SEARCH  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REPLACE = 3'd4
  } op_t;

  // Broadcast command to every cell of the chain
  typedef struct packed {
    logic ins_en;
    logic del_en;
    logic rep_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/iale_cell.sv -----
`default_nettype none

module iale_cell #(
  parameter int IDX = 0,
  parameter int DW  = 32,
  parameter int IW  = 5
) (
  input  wire                    clk,
  input  wire iale_pkg::cell_ctl_t ctl_i,
  input  wire [IW-1:0]           pos_i,
  input  wire [IW-1:0]           count_i,
  input  wire [DW-1:0]           value_i,
  input  wire [DW-1:0]           left_i,
  input  wire [DW-1:0]           right_i,
  output logic [DW-1:0]          data_o,
  output logic                   match_o
);
  import iale_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DW-1:0] data_r;
  logic [DW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins_en) begin
      if (MY_IDX > pos_i) begin
        data_nxt = left_i;
      end else if (MY_IDX == pos_i) begin
        data_nxt = value_i;
      end
    end
    if (ctl_i.del_en && (MY_IDX >= pos_i)) begin
      data_nxt = right_i;
    end
    if (ctl_i.rep_en && (MY_IDX == pos_i)) begin
      data_nxt = value_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  // only entries below the count take part in a search
  assign match_o = (data_r == value_i) && (MY_IDX < count_i);

endmodule

`default_nettype wire

// ----- rtl/indexed_array_list_engine_core.sv -----
`default_nettype none

// Indexed array list engine. Holds an ordered list of up to CAPACITY entries in
// a chain of cells; insert, remove, replace, select and search each run as one
// command transaction. A command is taken on a rising edge with start high and
// busy low; busy then stays high through the execute and response states while
// the cells shift or compare and the match vector is encoded, and the result
// appears on the out_ ports for exactly one cycle with out_strobe high, in the
// same cycle that busy drops. A new command is accepted only once busy has
// dropped, after the cell update and the first-match encode and entry readout.
// The receiver cannot stall: capture every result in the cycle its strobe is
// high. The capacity register on the cfg_ port is always ready and must be
// written only while no command is in flight.
module indexed_array_list_engine_core #(
  parameter int CAPACITY   = iale_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = iale_pkg::DEF_DATA_WIDTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // command transaction
  input  wire                              start,
  output logic                             busy,
  input  wire [iale_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire [iale_pkg::POS_W-1:0]        in_position,
  input  wire signed [iale_pkg::VALUE_W-1:0] in_item_value,
  // result transaction
  output logic                             out_strobe,
  output logic                             out_ok,
  output logic signed [iale_pkg::VALUE_W-1:0] out_read_value,
  output logic [iale_pkg::POS_W-1:0]       out_found_index,
  output logic [iale_pkg::POS_W-1:0]       out_entry_count,
  output logic                             out_is_empty,
  output logic                             out_is_full,
  // capacity register
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [iale_pkg::CFG_W-1:0]        cfg_data
);
  import iale_pkg::*;

  localparam int DW = DATA_WIDTH;
  // count width, and a common width for comparing counts, positions and limits
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    cap_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;

  // captured command
  logic [OPCODE_W-1:0] req_op_r;
  logic [POS_W-1:0]    req_pos_r;
  logic [DW-1:0]       req_val_r;

  // results of the execute step
  logic                ok_r;
  logic                rd_en_r;
  logic                search_r;
  logic [IW-1:0]       sel_idx_r;
  logic [CAPACITY-1:0] match_r;

  // registered result transaction
  logic                out_strobe_r;
  logic                out_ok_r;
  logic [VALUE_W-1:0]  out_rd_r;
  logic [POS_W-1:0]    out_found_r;
  logic [POS_W-1:0]    out_count_r;
  logic                out_empty_r;
  logic                out_full_r;

  logic [63:0]         val_ext;
  logic [IW-1:0]       pos_x;
  logic [IW-1:0]       cnt_x;
  logic [IW-1:0]       lim_x;
  logic                ins_ok;
  logic                pos_in_range;
  logic                exec;
  cell_ctl_t           ctl;
  logic                ok_nxt;

  logic [DW-1:0]       data_w  [CAPACITY];
  logic [CAPACITY-1:0] match_w;
  logic [DW-1:0]       rd_data;
  logic [63:0]         rd_ext;
  logic [IW-1:0]       first_idx;
  logic [IW-1:0]       found_v;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign exec      = (state_r == S_EXEC);

  // keep the low DATA_WIDTH bits of the value, zero-extended when wider
  assign val_ext = {32'b0, in_item_value};

  // effective capacity: register value saturated at CAPACITY
  assign pos_x = IW'(req_pos_r);
  assign cnt_x = IW'(count_r);
  assign lim_x = (IW'(cap_r) > IW'(CAPACITY)) ? IW'(CAPACITY) : IW'(cap_r);

  assign ins_ok       = (cnt_x < lim_x) && (pos_x <= cnt_x);
  assign pos_in_range = (pos_x < cnt_x);

  // Decode the held command into the cell broadcast and the new count
  always_comb begin
    ctl       = '0;
    ok_nxt    = 1'b0;
    count_nxt = count_r;
    case (req_op_r)
      OP_SELECT: begin
        ok_nxt = 1'b1;
      end
      OP_SEARCH: begin
        ok_nxt = 1'b1;
      end
      OP_INSERT: begin
        ok_nxt     = ins_ok;
        ctl.ins_en = exec && ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        ok_nxt     = pos_in_range;
        ctl.del_en = exec && pos_in_range;
        if (pos_in_range) begin
          count_nxt = count_r - 1'b1;
        end
      end
      OP_REPLACE: begin
        ok_nxt     = pos_in_range;
        ctl.rep_en = exec && pos_in_range;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // Chain of cells: each holds one entry and shifts to or from its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_w;
    logic [DW-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = req_val_r;
    end else begin : g_mid_l
      assign left_w = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = data_w[i];
    end else begin : g_mid_r
      assign right_w = data_w[i+1];
    end

    iale_cell #(
      .IDX (i),
      .DW  (DW),
      .IW  (IW)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .pos_i   (pos_x),
      .count_i (cnt_x),
      .value_i (req_val_r),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[i]),
      .match_o (match_w[i])
    );
  end

  // Read the selected entry; cells hold still during a select
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_idx_r == IW'(i)) begin
        rd_data = rd_data | data_w[i];
      end
    end
  end

  assign rd_ext = 64'(rd_data);

  // First match wins; no match reports the count
  always_comb begin
    first_idx = cnt_x;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_idx = IW'(i);
      end
    end
  end

  assign found_v = search_r ? first_idx : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CFG_RESET;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          // capture the command transaction
          if (start) begin
            req_op_r  <= in_opcode;
            req_pos_r <= in_position;
            req_val_r <= val_ext[DW-1:0];
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          // cells update on this edge; hold the match vector and read index
          count_r   <= count_nxt;
          ok_r      <= ok_nxt;
          match_r   <= match_w;
          search_r  <= (req_op_r == OP_SEARCH);
          rd_en_r   <= (req_op_r == OP_SELECT) && (cnt_x != '0);
          sel_idx_r <= pos_in_range ? pos_x : (cnt_x - 1'b1);
          state_r   <= S_RESP;
        end
        S_RESP: begin
          // drive the result transaction for one cycle
          out_strobe_r <= 1'b1;
          out_ok_r     <= ok_r;
          out_rd_r     <= rd_en_r ? rd_ext[VALUE_W-1:0] : '0;
          out_found_r  <= POS_W'(found_v);
          out_count_r  <= POS_W'(count_r);
          out_empty_r  <= (cnt_x == '0);
          out_full_r   <= (cnt_x >= lim_x);
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_ok          = out_ok_r;
  assign out_read_value  = out_rd_r;
  assign out_found_index = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

`default_nettype wire

// ----- tb/indexed_array_list_engine_core_tb.sv -----
module indexed_array_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iale_pkg::*;

  localparam int CAPACITY       = DEF_CAPACITY;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int REPORT_MAX     = 10;
  localparam int CHUNK_ITEMS    = 133;

  // Opcodes the block does not decode; they must leave the list alone
  localparam logic [OPCODE_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_MID   = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   found_index;
    logic [POS_W-1:0]   entry_count;
    logic               is_empty;
    logic               is_full;
  } list_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [OPCODE_W-1:0]        in_opcode;
  logic [POS_W-1:0]           in_position;
  logic signed [VALUE_W-1:0]  in_item_value;
  logic                       out_strobe;
  logic                       out_ok;
  logic signed [VALUE_W-1:0]  out_read_value;
  logic [POS_W-1:0]           out_found_index;
  logic [POS_W-1:0]           out_entry_count;
  logic                       out_is_empty;
  logic                       out_is_full;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_data;

  // Shadow copy of the list, its count and the capacity register
  logic [VALUE_W-1:0] list_store [CAPACITY];
  int unsigned        list_count;
  logic [CFG_W-1:0]   capacity_reg;

  list_result_t pending_results[$];
  int unsigned  mismatch_count;
  int unsigned  idle_pct;
  int unsigned  quiet_cycles;

  indexed_array_list_engine_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_strobe      (out_strobe),
    .out_ok          (out_ok),
    .out_read_value  (out_read_value),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Capacity register values above the physical depth saturate
  function automatic int unsigned active_limit();
    return (capacity_reg > CAPACITY) ? CAPACITY : capacity_reg;
  endfunction

  // Apply one command to the shadow list and return the result it should produce
  function automatic list_result_t list_apply(input logic [OPCODE_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [VALUE_W-1:0] val);
    list_result_t r;
    int unsigned  i;
    logic         hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_SELECT: begin
        r.ok = 1'b1;
        // past the end reads the last entry; an empty list reads zero
        if (list_count > 0)
          r.read_value = (pos < list_count) ? list_store[pos] : list_store[list_count-1];
      end
      OP_SEARCH: begin
        r.ok          = 1'b1;
        r.found_index = POS_W'(list_count);
        for (i = 0; i < list_count; i++) begin
          if (!hit && list_store[i] == val) begin
            r.found_index = POS_W'(i);
            hit           = 1'b1;
          end
        end
      end
      OP_INSERT: begin
        if (list_count < active_limit() && pos <= list_count) begin
          for (i = list_count; i > pos; i--)
            list_store[i] = list_store[i-1];
          list_store[pos] = val;
          list_count++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < list_count) begin
          list_count--;
          for (i = pos; i < list_count; i++)
            list_store[i] = list_store[i+1];
          r.ok = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (pos < list_count) begin
          list_store[pos] = val;
          r.ok            = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = POS_W'(list_count);
    r.is_empty    = (list_count == 0);
    r.is_full     = (list_count >= active_limit());
    return r;
  endfunction

  // Hold start low for a few cycles so gaps land on every busy phase
  task automatic idle_gap(input int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drive one command transaction; predict its result once the block takes it
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val);
    @(negedge clk);
    start         <= 1'b1;
    in_opcode     <= op;
    in_position   <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(list_apply(op, pos, val));
    if (idle_pct != 0 && $urandom_range(99) < idle_pct)
      idle_gap($urandom_range(4, 1));
  endtask

  // Drop start and wait until every predicted result has been seen
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register while no command is in flight
  task automatic set_capacity(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(7);  // small values give duplicates for search
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_capacity();
    case ($urandom_range(5))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      default: return CFG_W'($urandom_range(31));
    endcase
  endfunction

  // Empty list: every read and edit on no entries, plus undecoded opcodes
  task automatic test_empty_list();
    send_cmd(OP_SELECT, 5'd31, 32'h0);
    send_cmd(OP_SEARCH, 5'd0, 32'h0);
    send_cmd(OP_REMOVE, 5'd0, 32'h0);
    send_cmd(OP_REPLACE, 5'd0, 32'h1234_5678);
    send_cmd(OP_INSERT, 5'd1, 32'h1);
    send_cmd(OP_RSVD_FIRST, 5'd0, 32'hFFFF_FFFF);
    send_cmd(OP_RSVD_MID, 5'd31, 32'h0);
    send_cmd(OP_RSVD_LAST, 5'd16, 32'h8000_0000);
  endtask

  // Front and back edits with extreme values, with out-of-range requests among them
  task automatic test_edit_operations();
    send_cmd(OP_INSERT, 5'd0, 32'h8000_0000);
    send_cmd(OP_INSERT, POS_W'(list_count), 32'h7FFF_FFFF);
    send_cmd(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_cmd(OP_INSERT, 5'd31, 32'h5);
    send_cmd(OP_SELECT, 5'd0, 32'h0);
    send_cmd(OP_SELECT, 5'd31, 32'h0);
    send_cmd(OP_SEARCH, 5'd0, 32'h7FFF_FFFF);
    send_cmd(OP_SEARCH, 5'd0, 32'h0);
    send_cmd(OP_REPLACE, POS_W'(list_count - 1), 32'h0);
    send_cmd(OP_REPLACE, POS_W'(list_count), 32'h1);
    send_cmd(OP_REMOVE, 5'd0, 32'h0);
    send_cmd(OP_REMOVE, POS_W'(list_count - 1), 32'h0);
    send_cmd(OP_REMOVE, 5'd5, 32'h0);
  endtask

  // Capacity below the count, zero capacity, and saturation above the depth
  task automatic test_capacity_register();
    set_capacity(5'd1);
    send_cmd(OP_INSERT, 5'd0, 32'hA5A5_A5A5);
    set_capacity(5'd0);
    send_cmd(OP_REMOVE, 5'd0, 32'h0);
    send_cmd(OP_INSERT, 5'd0, 32'h1);
    set_capacity(5'd31);
    send_cmd(OP_INSERT, 5'd0, 32'h5A5A_5A5A);
    send_cmd(OP_SELECT, 5'd0, 32'h0);
  endtask

  // Mostly legal edits at valid positions, with some noise and bad positions
  task automatic run_random(input int unsigned n);
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  val;
    int unsigned         w;
    for (int unsigned k = 0; k < n; k++) begin
      w = $urandom_range(99);
      if (w < 35)      op = OP_INSERT;
      else if (w < 55) op = OP_REMOVE;
      else if (w < 70) op = OP_SELECT;
      else if (w < 85) op = OP_SEARCH;
      else if (w < 95) op = OP_REPLACE;
      else             op = OPCODE_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
      pos = ($urandom_range(9) < 8) ? POS_W'($urandom_range(list_count))
                                    : POS_W'($urandom_range(31));
      if (op == OP_SEARCH && list_count > 0 && $urandom_range(1) == 1)
        val = list_store[$urandom_range(list_count - 1)];
      else
        val = rand_value();
      send_cmd(op, pos, val);
    end
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle);
    idle_pct = sender_idle;
    for (int unsigned c = 0; c < 4; c++) begin
      set_capacity(rand_capacity());
      run_random(CHUNK_ITEMS);
    end
  endtask

  // Check each result against the oldest prediction, sampled at the rising edge
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_strobe) begin
      got = '{out_ok, out_read_value, out_found_index, out_entry_count,
              out_is_empty, out_is_full};
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("unexpected result: ok=%0d rd=%h idx=%0d cnt=%0d empty=%0d full=%0d",
                   got.ok, got.read_value, got.found_index, got.entry_count,
                   got.is_empty, got.is_full);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          if (mismatch_count < REPORT_MAX)
            $display("mismatch: exp ok=%0d rd=%h idx=%0d cnt=%0d empty=%0d full=%0d",
                     want.ok, want.read_value, want.found_index, want.entry_count,
                     want.is_empty, want.is_full,
                     " / act ok=%0d rd=%h idx=%0d cnt=%0d empty=%0d full=%0d",
                     got.ok, got.read_value, got.found_index, got.entry_count,
                     got.is_empty, got.is_full);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles in which no transaction of any kind completes
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("indexed_array_list_engine_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_opcode      = OP_SELECT;
    in_position    = '0;
    in_item_value  = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    list_count     = 0;
    capacity_reg   = CFG_RESET;
    mismatch_count = 0;
    idle_pct       = 0;
    quiet_cycles   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_edit_operations();
    test_capacity_register();
    test_random_traffic(35);
    test_random_traffic(75);
    test_random_traffic(0);
    drain_results();

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("indexed_array_list_engine_core regression: pass");
    else
      $display("indexed_array_list_engine_core regression: fail");
    $finish;
  end

endmodule

// ----- indexed_array_list_engine_core.f -----
rtl/iale_pkg.sv
rtl/iale_cell.sv
rtl/indexed_array_list_engine_core.sv
tb/indexed_array_list_engine_core_tb.sv
